// File: design/k_way_merge_min_heap_unit_assert.svh
// assertion macros used by the checker file kwm_checker.sv
`ifndef K_WAY_MERGE_MIN_HEAP_UNIT_ASSERT_SVH
`define K_WAY_MERGE_MIN_HEAP_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define KWM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kwm assertion failed");

// next-cycle implication, disabled in reset
`define KWM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kwm assertion failed");

`endif

// File: design/kwm_pkg.sv
package kwm_pkg;

    localparam int VALUE_W   = 32;
    localparam int WAY_OUT_W = 3;

    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_REFILL = 2'd2,
        OP_EXHAUST = 2'd3
    } t_op;

    // one heap slot: head value and its way number
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [WAY_OUT_W-1:0]      way;
    } t_entry;

    // decision of the sift compare unit
    typedef struct packed {
        logic move;   // a child is strictly smaller than the sifted entry
        logic right;  // the right child wins
    } t_sift_dec;

endpackage

// File: design/kwm_heap_mem.sv
module kwm_heap_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  kwm_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr_a,
    input  logic [AW-1:0]   i_raddr_b,
    output kwm_pkg::t_entry o_rdata_a,
    output kwm_pkg::t_entry o_rdata_b
);

    kwm_pkg::t_entry r_mem [DEPTH];
    kwm_pkg::t_entry r_rdata_a;
    kwm_pkg::t_entry r_rdata_b;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: design/kwm_sift_cmp.sv
module kwm_sift_cmp (
    input  logic signed [kwm_pkg::VALUE_W-1:0] i_v,
    input  logic signed [kwm_pkg::VALUE_W-1:0] i_left,
    input  logic signed [kwm_pkg::VALUE_W-1:0] i_right,
    input  logic                               i_left_ok,
    input  logic                               i_right_ok,
    output kwm_pkg::t_sift_dec                 o_dec
);

    logic                               take_left;
    logic                               take_right;
    logic signed [kwm_pkg::VALUE_W-1:0] best;

    // left child first, right child only if strictly below the running best
    always_comb begin
        take_left  = i_left_ok && (i_left < i_v);
        best       = take_left ? i_left : i_v;
        take_right = i_right_ok && (i_right < best);
        o_dec.move  = take_left || take_right;
        o_dec.right = take_right;
    end

endmodule

// File: design/k_way_merge_min_heap_unit.sv
// channel | valid       | ready       | payload
// in      | i_in_valid  | o_in_ready  | i_operation, i_value
// out     | o_out_valid | i_out_ready | o_min_value, o_min_way, o_done_res
//
// load: never an item. start: sifts nodes (n+1)/2-1 down to 0 (n = ways loaded) as
// refill/exhaust sift the root: each level a child read (S_RDC) and compare (S_CMP)
// (one compare unit, registered heap reads), then S_RRD/S_RCAP read the root; input is
// taken again after S_EMIT. Merge-ending exhaust or empty start: straight to S_EMIT.
// reset clears the phase and counters; the heap memory needs no clearing.
// a finished item waits in the output register while new items are taken.
module k_way_merge_min_heap_unit #(
    parameter int WAYS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_operation,
    input  logic signed [kwm_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [kwm_pkg::VALUE_W-1:0] o_min_value,
    output logic [kwm_pkg::WAY_OUT_W-1:0]      o_min_way,
    output logic                               o_done_res
);

    localparam int IDX_W = $clog2(WAYS);
    localparam int CNT_W = $clog2(WAYS + 1);
    localparam int CH_W  = IDX_W + 2;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_HRD  = 8'b0000_0010,
        S_HLD  = 8'b0000_0100,
        S_RDC  = 8'b0000_1000,
        S_CMP  = 8'b0001_0000,
        S_RRD  = 8'b0010_0000,
        S_RCAP = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    typedef enum logic [2:0] {
        PH_LOAD  = 3'b001,
        PH_MERGE = 3'b010,
        PH_DONE  = 3'b100
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [CNT_W-1:0] r_loaded, n_loaded;
    logic [CNT_W-1:0] r_exh, n_exh;
    logic             r_heapify, n_heapify;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_lc, n_lc;
    logic [IDX_W-1:0] r_rc, n_rc;
    logic             r_lv, n_lv;
    logic             r_rv, n_rv;
    kwm_pkg::t_entry  r_v, n_v;
    logic [kwm_pkg::WAY_OUT_W-1:0] r_root_way, n_root_way;
    kwm_pkg::t_entry  r_res, n_res;
    logic             r_res_done, n_res_done;
    logic             r_ov, n_ov;
    logic signed [kwm_pkg::VALUE_W-1:0] r_ovalue, n_ovalue;
    logic [kwm_pkg::WAY_OUT_W-1:0]      r_oway, n_oway;
    logic             r_odone, n_odone;

    logic             in_acc;
    logic             out_free;
    logic [CH_W-1:0]  lc_full;
    logic [CH_W-1:0]  rc_full;
    logic [CH_W-1:0]  n_ext;
    logic [CNT_W:0]   half_cnt;
    logic [CNT_W-1:0] exh_inc;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    kwm_pkg::t_entry  mem_wdata;
    logic [IDX_W-1:0] mem_ra;
    logic [IDX_W-1:0] mem_rb;
    kwm_pkg::t_entry  rd_a;
    kwm_pkg::t_entry  rd_b;
    kwm_pkg::t_sift_dec dec;

    kwm_heap_mem #(
        .DEPTH (WAYS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_ra),
        .i_raddr_b (mem_rb),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    kwm_sift_cmp u_cmp (
        .i_v        (r_v.value),
        .i_left     (rd_a.value),
        .i_right    (rd_b.value),
        .i_left_ok  (r_lv),
        .i_right_ok (r_rv),
        .o_dec      (dec)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;

    // child positions of the current hole, heap size, heapify start and next exhaust count
    always_comb begin
        lc_full  = {1'b0, r_pos, 1'b0} + CH_W'(1);
        rc_full  = {1'b0, r_pos, 1'b0} + CH_W'(2);
        n_ext    = CH_W'(r_loaded);
        half_cnt = ({1'b0, r_loaded} + (CNT_W + 1)'(1)) >> 1;
        exh_inc  = r_exh + CNT_W'(1);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_loaded   = r_loaded;
        n_exh      = r_exh;
        n_heapify  = r_heapify;
        n_k        = r_k;
        n_pos      = r_pos;
        n_lc       = r_lc;
        n_rc       = r_rc;
        n_lv       = r_lv;
        n_rv       = r_rv;
        n_v        = r_v;
        n_root_way = r_root_way;
        n_res      = r_res;
        n_res_done = r_res_done;
        n_ov       = r_ov && !i_out_ready;
        n_ovalue   = r_ovalue;
        n_oway     = r_oway;
        n_odone    = r_odone;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = r_v;
        mem_ra     = r_pos;
        mem_rb     = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (kwm_pkg::t_op'(i_operation))
                        kwm_pkg::OP_LOAD: begin
                            if (r_phase == PH_LOAD && r_loaded < CNT_W'(WAYS)) begin
                                mem_we          = 1'b1;
                                mem_waddr       = IDX_W'(r_loaded);
                                mem_wdata.value = i_value;
                                mem_wdata.way   = kwm_pkg::WAY_OUT_W'(r_loaded);
                                n_loaded        = r_loaded + CNT_W'(1);
                            end
                        end
                        kwm_pkg::OP_START: begin
                            if (r_phase == PH_LOAD) begin
                                if (r_loaded == '0) begin
                                    n_phase    = PH_DONE;
                                    n_res_done = 1'b1;
                                    n_state    = S_EMIT;
                                end else begin
                                    n_phase    = PH_MERGE;
                                    n_heapify  = 1'b1;
                                    n_k        = IDX_W'(half_cnt - (CNT_W + 1)'(1));
                                    n_state    = S_HRD;
                                end
                            end
                        end
                        kwm_pkg::OP_REFILL: begin
                            if (r_phase == PH_MERGE) begin
                                n_heapify = 1'b0;
                                n_pos     = '0;
                                n_v.value = i_value;
                                n_v.way   = r_root_way;
                                n_state   = S_RDC;
                            end
                        end
                        kwm_pkg::OP_EXHAUST: begin
                            if (r_phase == PH_MERGE) begin
                                n_exh = exh_inc;
                                // last way gone: heap contents no longer matter
                                if (exh_inc >= r_loaded) begin
                                    n_phase    = PH_DONE;
                                    n_res_done = 1'b1;
                                    n_state    = S_EMIT;
                                end else begin
                                    n_heapify = 1'b0;
                                    n_pos     = '0;
                                    n_v.value = kwm_pkg::INT_MAX;
                                    n_v.way   = r_root_way;
                                    n_state   = S_RDC;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // fetch the entry that heapify sifts next
            S_HRD: begin
                mem_ra  = r_k;
                n_state = S_HLD;
            end
            S_HLD: begin
                n_v     = rd_a;
                n_pos   = r_k;
                n_state = S_RDC;
            end
            // read both children of the hole
            S_RDC: begin
                mem_ra  = lc_full[IDX_W-1:0];
                mem_rb  = rc_full[IDX_W-1:0];
                n_lc    = lc_full[IDX_W-1:0];
                n_rc    = rc_full[IDX_W-1:0];
                n_lv    = lc_full < n_ext;
                n_rv    = rc_full < n_ext;
                n_state = S_CMP;
            end
            // move the smaller child up, or settle the sifted entry
            S_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                if (dec.move) begin
                    mem_wdata = dec.right ? rd_b : rd_a;
                    n_pos     = dec.right ? r_rc : r_lc;
                    n_state   = S_RDC;
                end else begin
                    mem_wdata = r_v;
                    if (r_heapify && r_k != '0) begin
                        n_k     = r_k - IDX_W'(1);
                        n_state = S_HRD;
                    end else begin
                        n_state = S_RRD;
                    end
                end
            end
            S_RRD: begin
                mem_ra  = '0;
                n_state = S_RCAP;
            end
            S_RCAP: begin
                n_res      = rd_a;
                n_root_way = rd_a.way;
                n_res_done = 1'b0;
                n_state    = S_EMIT;
            end
            // hand the item to the output register
            S_EMIT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_ovalue = r_res_done ? '0 : r_res.value;
                    n_oway   = r_res_done ? '0 : r_res.way;
                    n_odone  = r_res_done;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_LOAD;
            r_loaded <= '0;
            r_exh    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_loaded <= n_loaded;
            r_exh    <= n_exh;
            r_ov     <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_heapify  <= n_heapify;
        r_k        <= n_k;
        r_pos      <= n_pos;
        r_lc       <= n_lc;
        r_rc       <= n_rc;
        r_lv       <= n_lv;
        r_rv       <= n_rv;
        r_v        <= n_v;
        r_root_way <= n_root_way;
        r_res      <= n_res;
        r_res_done <= n_res_done;
        r_ovalue   <= n_ovalue;
        r_oway     <= n_oway;
        r_odone    <= n_odone;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_min_value = r_ovalue;
    assign o_min_way   = r_oway;
    assign o_done_res  = r_odone;

endmodule

// File: design/kwm_checker.sv
`include "k_way_merge_min_heap_unit_assert.svh"

module kwm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic [1:0]                         i_operation,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [kwm_pkg::VALUE_W-1:0] o_min_value,
    input logic [kwm_pkg::WAY_OUT_W-1:0]      o_min_way,
    input logic                               o_done_res
);

    logic load_acc;
    logic done_taken;
    logic done_out;
    logic min_zero;

    assign load_acc   = i_in_valid && o_in_ready &&
                        (i_operation == kwm_pkg::OP_LOAD);
    assign done_taken = o_out_valid && i_out_ready && o_done_res;
    assign done_out   = o_out_valid && o_done_res;
    assign min_zero   = (o_min_value == '0) && (o_min_way == '0);

    // a stalled item stays offered
    `KWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    // a done item carries no minimum
    `KWM_ASSERT_NOW(a_done_zero, i_clk, i_rst_n, done_out, min_zero)
    // a load never creates an item
    `KWM_ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, load_acc && !o_out_valid, !o_out_valid)
    // nothing follows right after the done item
    `KWM_ASSERT_NEXT(a_after_done, i_clk, i_rst_n, done_taken, !o_out_valid)

endmodule

bind k_way_merge_min_heap_unit kwm_checker u_kwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_operation (i_operation),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_min_value (o_min_value),
    .o_min_way   (o_min_way),
    .o_done_res  (o_done_res)
);

// File: tb/tb_top.sv
module tb_top;

    localparam int WAYS         = 8;
    localparam int IDLE_PCT     = 38;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS = 1120;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_MERGING,
        PH_DONE
    } t_merge_phase;

    // one expected merge output
    typedef struct {
        logic signed [kwm_pkg::VALUE_W-1:0] value;
        logic [kwm_pkg::WAY_OUT_W-1:0]      way;
        logic                               done;
    } t_min_result;

    logic                               i_clk;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_ready;
    logic [1:0]                         i_operation = kwm_pkg::OP_LOAD;
    logic signed [kwm_pkg::VALUE_W-1:0] i_value     = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic signed [kwm_pkg::VALUE_W-1:0] o_min_value;
    logic [kwm_pkg::WAY_OUT_W-1:0]      o_min_way;
    logic                               o_done_res;

    // predicted heap and merge progress
    logic signed [kwm_pkg::VALUE_W-1:0] heap_val [WAYS];
    int unsigned                        heap_way [WAYS];
    int                                 ways_loaded    = 0;
    int                                 ways_exhausted = 0;
    t_merge_phase                       merge_phase    = PH_LOADING;
    t_min_result                        pending_mins[$];

    int          err_count  = 0;
    int unsigned cycle_count = 0;
    bit          tx_steady  = 1'b0;
    bit          rx_steady  = 1'b0;
    int          rx_hold_requests = 0;
    int          rx_hold_served   = 0;
    int          rx_hold_left     = 0;

    k_way_merge_min_heap_unit #(
        .WAYS(WAYS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_operation(i_operation),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_min_value(o_min_value),
        .o_min_way  (o_min_way),
        .o_done_res (o_done_res)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // push the entry at pos down until no child is strictly smaller
    function automatic void sift_heap(int start_pos);
        int                                 pos;
        int                                 lc;
        int                                 rc;
        int                                 best;
        logic signed [kwm_pkg::VALUE_W-1:0] tv;
        int unsigned                        tw;
        pos = start_pos;
        while (pos < ways_loaded) begin
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            best = pos;
            if (lc < ways_loaded && heap_val[lc] < heap_val[pos]) best = lc;
            if (rc < ways_loaded && heap_val[rc] < heap_val[best]) best = rc;
            if (best == pos) break;
            tv             = heap_val[pos];
            tw             = heap_way[pos];
            heap_val[pos]  = heap_val[best];
            heap_way[pos]  = heap_way[best];
            heap_val[best] = tv;
            heap_way[best] = tw;
            pos = best;
        end
    endfunction

    function automatic void queue_current_min();
        t_min_result r;
        if (merge_phase == PH_DONE) begin
            r.value = '0;
            r.way   = '0;
            r.done  = 1'b1;
        end else begin
            r.value = heap_val[0];
            r.way   = heap_way[0][kwm_pkg::WAY_OUT_W-1:0];
            r.done  = 1'b0;
        end
        pending_mins.push_back(r);
    endfunction

    // advance the predicted merge by one accepted item
    function automatic void predict_merge_step(kwm_pkg::t_op op,
                                               logic signed [kwm_pkg::VALUE_W-1:0] val);
        int k;
        case (op)
            kwm_pkg::OP_LOAD: begin
                if (merge_phase == PH_LOADING && ways_loaded < WAYS) begin
                    heap_val[ways_loaded] = val;
                    heap_way[ways_loaded] = ways_loaded;
                    ways_loaded++;
                end
            end
            kwm_pkg::OP_START: begin
                if (merge_phase == PH_LOADING) begin
                    if (ways_loaded == 0) begin
                        merge_phase = PH_DONE;
                    end else begin
                        for (k = (ways_loaded + 1) / 2 - 1; k >= 0; k--) sift_heap(k);
                        merge_phase = PH_MERGING;
                    end
                    queue_current_min();
                end
            end
            kwm_pkg::OP_REFILL: begin
                if (merge_phase == PH_MERGING) begin
                    heap_val[0] = val;
                    sift_heap(0);
                    queue_current_min();
                end
            end
            default: begin
                if (merge_phase == PH_MERGING) begin
                    heap_val[0] = kwm_pkg::INT_MAX;
                    ways_exhausted++;
                    sift_heap(0);
                    if (ways_exhausted >= ways_loaded) merge_phase = PH_DONE;
                    queue_current_min();
                end
            end
        endcase
    endfunction

    // next head for the way at the root: mostly a sorted continuation
    function automatic logic signed [kwm_pkg::VALUE_W-1:0] next_head_value();
        int unsigned                        pick;
        longint                             nv;
        logic signed [kwm_pkg::VALUE_W-1:0] raw;
        pick = $urandom_range(99);
        raw  = $urandom;
        if (pick < 70) begin
            nv = longint'(heap_val[0]) + longint'($urandom_range(40));
        end else if (pick < 85) begin
            nv = longint'($urandom_range(15)) - 8;
        end else if (pick < 95) begin
            nv = raw;
        end else begin
            case ($urandom_range(3))
                0:       nv = -64'sd2147483648;
                1:       nv = kwm_pkg::INT_MAX;
                2:       nv = 0;
                default: nv = -1;
            endcase
        end
        if (nv > longint'(kwm_pkg::INT_MAX)) nv = kwm_pkg::INT_MAX;
        return nv[kwm_pkg::VALUE_W-1:0];
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(input kwm_pkg::t_op op,
                             input logic signed [kwm_pkg::VALUE_W-1:0] val);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_merge_step(op, val);
        if (!tx_steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // stop sending until every expected item is back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_mins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_ops_before_start();
        send_item(kwm_pkg::OP_REFILL, 32'sh5A5A_A5A5);
        send_item(kwm_pkg::OP_EXHAUST, 32'sh7FFF_0000);
    endtask

    // extremes, ties, INT_MAX heads and loads past the last way
    task automatic test_load_heads();
        send_item(kwm_pkg::OP_LOAD, 32'sd17);
        send_item(kwm_pkg::OP_LOAD, kwm_pkg::INT_MAX);
        send_item(kwm_pkg::OP_LOAD, -32'sd1);
        send_item(kwm_pkg::OP_LOAD, 32'sh8000_0000);
        send_item(kwm_pkg::OP_LOAD, 32'sd0);
        send_item(kwm_pkg::OP_LOAD, -32'sd1);
        send_item(kwm_pkg::OP_LOAD, kwm_pkg::INT_MAX);
        send_item(kwm_pkg::OP_LOAD, 32'sd17);
        send_item(kwm_pkg::OP_LOAD, -32'sd100);
        send_item(kwm_pkg::OP_LOAD, 32'sh8000_0000);
    endtask

    // start, then a second start and a late load that must be ignored
    task automatic test_start_merge();
        send_item(kwm_pkg::OP_START, 32'sd0);
        send_item(kwm_pkg::OP_START, 32'sd0);
        send_item(kwm_pkg::OP_LOAD, 32'sh8000_0000);
    endtask

    task automatic test_directed_refills();
        send_item(kwm_pkg::OP_REFILL, 32'sh8000_0000);
        send_item(kwm_pkg::OP_REFILL, kwm_pkg::INT_MAX);
        send_item(kwm_pkg::OP_REFILL, 32'sd0);
        send_item(kwm_pkg::OP_REFILL, -32'sd1);
        send_item(kwm_pkg::OP_REFILL, -32'sd1);
        send_item(kwm_pkg::OP_EXHAUST, 32'sd0);
        send_item(kwm_pkg::OP_REFILL, 32'sd17);
        wait_results_drained();
    endtask

    // long receiver hold while the sender keeps offering refills
    task automatic test_output_backpressure();
        int n;
        tx_steady = 1'b1;
        rx_hold_requests++;
        for (n = 0; n < 40; n++) send_item(kwm_pkg::OP_REFILL, next_head_value());
        tx_steady = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_random_merge();
        int          counted;
        int unsigned pick;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            tx_steady = (counted >= 500 && counted < 700);
            rx_steady = tx_steady;
            pick = $urandom_range(999);
            // loads and starts are ignored while merging
            if (pick < 25) begin
                send_item(kwm_pkg::OP_LOAD, $urandom);
            end else if (pick < 50) begin
                send_item(kwm_pkg::OP_START, $urandom);
            end else if (pick < 60 && ways_exhausted < ways_loaded - 2) begin
                send_item(kwm_pkg::OP_EXHAUST, $urandom);
                counted++;
            end else begin
                send_item(kwm_pkg::OP_REFILL, next_head_value());
                counted++;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_results_drained();
    endtask

    // run the remaining ways dry, then everything is ignored
    task automatic test_exhaust_to_done();
        while (merge_phase != PH_DONE) begin
            if ($urandom_range(3) == 0) send_item(kwm_pkg::OP_REFILL, next_head_value());
            else send_item(kwm_pkg::OP_EXHAUST, $urandom);
        end
        send_item(kwm_pkg::OP_REFILL, 32'sd5);
        send_item(kwm_pkg::OP_EXHAUST, 32'sd0);
        send_item(kwm_pkg::OP_START, 32'sd0);
        send_item(kwm_pkg::OP_LOAD, -32'sd1);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (rx_hold_requests != rx_hold_served) begin
            rx_hold_served = rx_hold_requests;
            rx_hold_left   = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare each delivered item with the oldest expected minimum
    always @(posedge i_clk) begin : check_results
        t_min_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_mins.size() == 0) begin
                $display("%0t: unexpected item value=%0d way=%0d done=%0b",
                         $time, o_min_value, o_min_way, o_done_res);
                err_count++;
            end else begin
                want = pending_mins.pop_front();
                if (o_min_value !== want.value) begin
                    $display("%0t: min_value expected %0d actual %0d",
                             $time, want.value, o_min_value);
                    err_count++;
                end
                if (o_min_way !== want.way) begin
                    $display("%0t: min_way expected %0d actual %0d",
                             $time, want.way, o_min_way);
                    err_count++;
                end
                if (o_done_res !== want.done) begin
                    $display("%0t: done_res expected %0b actual %0b",
                             $time, want.done, o_done_res);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ops_before_start();
        test_load_heads();
        test_start_merge();
        test_directed_refills();
        test_output_backpressure();
        test_random_merge();
        test_exhaust_to_done();
        wait_results_drained();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
